// ----- hw/rtl/delay_line_pitch_shifter_assert.svh -----
// Assertion helpers for the RTL files; delay_line_pitch_shifter.sv includes them.
// Both sample on clk_i and are disabled while rst_ni is low.
`ifndef DELAY_LINE_PITCH_SHIFTER_ASSERT_SVH
`define DELAY_LINE_PITCH_SHIFTER_ASSERT_SVH

// cond must hold at every edge
`define DLPS_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// post must hold in the cycle after pre
`define DLPS_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

// ----- hw/rtl/dlps_pkg.sv -----
package dlps_pkg;

  localparam int unsigned BufDepth   = 16384;
  localparam int unsigned SampleBits = 24;
  localparam int unsigned FracBits   = SampleBits - 1;
  localparam int unsigned StoreBits  = SampleBits + 2;
  localparam int unsigned AddrW      = $clog2(BufDepth);

  localparam int unsigned WpW    = 14;
  localparam int unsigned RpW    = 30;
  localparam int unsigned SpeedW = 19;
  localparam int unsigned GainW  = 17;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 30;

  localparam int unsigned OneQ16   = 65536;
  localparam int unsigned WidthMin = 65536;
  localparam int unsigned WidthMax = 9990 * 65536;

  // divider: quotient and magnitude of the feedback sum
  localparam int unsigned DivW = StoreBits + 1;
  localparam int unsigned RemW = StoreBits + 1;

  // shared multiplier
  localparam int unsigned MulAW = StoreBits + 2;
  localparam int unsigned MulBW = GainW + 1;
  localparam int unsigned MulW  = MulAW + MulBW;
  localparam int unsigned SatW  = MulW + 2;

  localparam logic [CfgIdxW-1:0] CfgReadSpeed   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgLoopWidth   = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgFeedback    = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgOutputTrim  = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] CfgWetMix      = CfgIdxW'(4);

  function automatic logic signed [StoreBits-1:0] sat_store(input logic signed [SatW-1:0] v);
    logic signed [SatW-1:0] hi;
    logic signed [SatW-1:0] lo;
    hi = {{(SatW-StoreBits+1){1'b0}}, {(StoreBits-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[StoreBits-1:0];
    end else if (v < lo) begin
      return lo[StoreBits-1:0];
    end
    return v[StoreBits-1:0];
  endfunction

  function automatic logic signed [SampleBits-1:0] sat_sample(input logic signed [SatW-1:0] v);
    logic signed [SatW-1:0] hi;
    logic signed [SatW-1:0] lo;
    hi = {{(SatW-SampleBits+1){1'b0}}, {(SampleBits-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[SampleBits-1:0];
    end else if (v < lo) begin
      return lo[SampleBits-1:0];
    end
    return v[SampleBits-1:0];
  endfunction

endpackage

// ----- hw/rtl/dlps_ram.sv -----
module dlps_ram #(
  parameter int unsigned Depth = 16384,
  parameter int unsigned Width = 26
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- hw/rtl/dlps_div.sv -----
module dlps_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [dlps_pkg::DivW-1:0]      dvd_i,
  input  logic [dlps_pkg::StoreBits-1:0] dvs_i,
  output logic                           done_o,
  output logic [dlps_pkg::DivW-1:0]      quo_o
);
  import dlps_pkg::*;

  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [CntW-1:0]      cnt_q;
  logic                 done_q;
  logic [RemW-1:0]      rem_q;
  logic [DivW-1:0]      dvd_q;
  logic [DivW-1:0]      quo_q;
  logic [StoreBits-1:0] dvs_q;
  logic [RemW-1:0]      trial;
  logic                 fits;

  // restoring step: bring down one dividend bit (dividend is m << FracBits)
  assign trial = {rem_q[RemW-2:0], dvd_q[DivW-1]};
  assign fits  = trial >= RemW'(dvs_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CntW'(DivW);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == CntW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      // upper dividend bits are below the divisor, so no quotient bits there
      rem_q <= RemW'(dvd_i >> (DivW - FracBits));
      dvd_q <= dvd_i << FracBits;
      quo_q <= '0;
      dvs_q <= dvs_i;
    end else if (cnt_q != '0) begin
      rem_q <= fits ? (trial - RemW'(dvs_q)) : trial;
      dvd_q <= dvd_q << 1;
      quo_q <= {quo_q[DivW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- hw/rtl/delay_line_pitch_shifter.sv -----
// An input transfer runs the sum, write, read, crossfade, mix, trim and wet steps to
//   out_valid_o, with the 27-step divider on the feedback sum when the last output
//   exceeds unity. Input waits until the result is in the output register, which
//   waits for a pending output; one shared multiplier and one single-port-read
//   sample RAM are walked step by step. Reset: pointers, crossfade and registers
//   take defaults; a clearing pass zeroes all 16384 entries before in_ready_o rises.
module delay_line_pitch_shifter (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [dlps_pkg::CfgIdxW-1:0]           cfg_idx_i,
  input  logic [dlps_pkg::CfgDataW-1:0]          cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [dlps_pkg::SampleBits-1:0] in_sample_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [dlps_pkg::SampleBits-1:0] out_sample_o
);
  import dlps_pkg::*;

  `include "delay_line_pitch_shifter_assert.svh"

  localparam int unsigned SumW = StoreBits + 2;

  typedef enum logic [4:0] {
    S_IDLE, S_SUM, S_DIV, S_WR, S_RD0, S_RD1, S_RD2, S_RD3, S_CF,
    S_MIX0, S_MIX1, S_MIX2, S_TRIM, S_WET0, S_WET1, S_OUT
  } state_e;

  // configuration
  logic [SpeedW-1:0] speed_q;
  logic [RpW-1:0]    width_q;
  logic [GainW-1:0]  gain_q;
  logic [GainW-1:0]  trim_q;
  logic [GainW-1:0]  wet_q;

  state_e state_q;

  // block state
  logic [WpW-1:0]              wp_q;
  logic [RpW-1:0]              rp_q;
  logic                        armed_q;
  logic [GainW-1:0]            cf_q;
  logic signed [StoreBits-1:0] last_q;

  // clearing pass
  logic             clearing_q;
  logic [AddrW-1:0] clr_q;

  // per-sample working registers
  logic signed [SampleBits-1:0] x_q;
  logic signed [MulW-1:0]       prod_q;
  logic signed [MulW-1:0]       prod_b_q;
  logic                         neg_q;
  logic signed [StoreBits-1:0]  wdata_q;
  logic [WpW:0]                 i0_q;
  logic [WpW:0]                 i1_q;
  logic [WpW-1:0]               curi_q;
  logic [15:0]                  frac_q;
  logic signed [StoreBits-1:0]  cur_q;
  logic signed [StoreBits-1:0]  interp_q;
  logic                         out_valid_q;
  logic signed [SampleBits-1:0] out_q;

  // datapath nets
  logic signed [MulAW-1:0]  mul_a;
  logic signed [MulBW-1:0]  mul_b;
  logic signed [MulW-1:0]   prod;
  logic signed [MulW:0]     psum;
  logic signed [SumW-1:0]   fb_sum;
  logic [DivW-1:0]          fb_mag;
  logic signed [StoreBits:0] last_ext;
  logic [StoreBits-1:0]     afb;
  logic                     need_div;
  logic                     div_done;
  logic [DivW-1:0]          div_quo;
  logic signed [SumW-1:0]   div_signed;
  logic                     in_xfer;

  logic [RpW-1:0] w_clamp;
  logic [WpW-1:0] wp_inc;
  logic [RpW-1:0] rp_inc;
  logic [RpW-1:0] wp16;
  logic [WpW-1:0] wp_next;
  logic [RpW-1:0] rp_next;
  logic [WpW-1:0] count;
  logic [WpW-1:0] aw;
  logic [WpW:0]   count1;

  logic signed [StoreBits:0] rw_diff;
  logic [StoreBits-1:0]      diff_mag;
  logic [GainW+2:0]          cf_decay;
  logic [GainW-1:0]          cf_next;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [StoreBits-1:0] ram_wdata;
  logic [AddrW-1:0] ram_raddr;
  logic [StoreBits-1:0] ram_rdata;

  assign in_ready_o   = (state_q == S_IDLE) && !clearing_q;
  assign in_xfer      = in_valid_i && in_ready_o;
  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= SpeedW'(65536);
      width_q <= RpW'(12026982);
      gain_q  <= '0;
      trim_q  <= GainW'(OneQ16);
      wet_q   <= GainW'(OneQ16);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgReadSpeed:  speed_q <= cfg_data_i[SpeedW-1:0];
        CfgLoopWidth:  width_q <= cfg_data_i[RpW-1:0];
        CfgFeedback:   gain_q  <= cfg_data_i[GainW-1:0];
        CfgOutputTrim: trim_q  <= cfg_data_i[GainW-1:0];
        CfgWetMix:     wet_q   <= cfg_data_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  // shared multiplier, operands picked by sequencer step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_IDLE: begin
        mul_a = MulAW'(last_q);
        mul_b = signed'(MulBW'(gain_q));
      end
      S_RD1: begin
        mul_a = MulAW'(signed'(ram_rdata));
        mul_b = signed'(MulBW'(GainW'(OneQ16) - GainW'(frac_q)));
      end
      S_RD2: begin
        mul_a = MulAW'(signed'(ram_rdata));
        mul_b = signed'(MulBW'(frac_q));
      end
      S_MIX0: begin
        mul_a = MulAW'(cur_q);
        mul_b = signed'(MulBW'(cf_q));
      end
      S_MIX1: begin
        mul_a = MulAW'(interp_q);
        mul_b = signed'(MulBW'(GainW'(OneQ16) - cf_q));
      end
      S_TRIM: begin
        mul_a = MulAW'(last_q);
        mul_b = signed'(MulBW'(trim_q));
      end
      S_WET0: begin
        mul_a = MulAW'(prod_q >>> 16);
        mul_b = signed'(MulBW'(wet_q));
      end
      S_WET1: begin
        mul_a = MulAW'(x_q);
        mul_b = signed'(MulBW'(OneQ16)) - signed'(MulBW'(wet_q));
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;
  assign psum = (MulW+1)'(prod_q) + (MulW+1)'(prod_b_q);

  // feedback sum and overload check
  assign fb_sum   = SumW'(x_q) + SumW'(prod_q >>> 16);
  assign fb_mag   = DivW'(fb_sum < 0 ? -fb_sum : fb_sum);
  assign last_ext = (StoreBits+1)'(last_q);
  assign afb      = StoreBits'(last_ext < 0 ? -last_ext : last_ext);
  assign need_div = afb > StoreBits'(1 << FracBits);
  assign div_signed = neg_q ? -SumW'(div_quo) : SumW'(div_quo);

  dlps_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i ((state_q == S_SUM) && need_div),
    .dvd_i   (fb_mag),
    .dvs_i   (afb),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // pointer arithmetic
  always_comb begin
    w_clamp = width_q;
    if (width_q < RpW'(WidthMin)) begin
      w_clamp = RpW'(WidthMin);
    end else if (width_q > RpW'(WidthMax)) begin
      w_clamp = RpW'(WidthMax);
    end
    wp_inc  = wp_q + 1'b1;
    rp_inc  = rp_q + RpW'(speed_q);
    wp16    = {wp_inc, 16'b0};
    wp_next = (wp16 > w_clamp) ? WpW'((wp16 - w_clamp) >> 16) : wp_inc;
    rp_next = (rp_inc > w_clamp) ? (rp_inc - w_clamp) : rp_inc;
    count   = rp_next[RpW-1:16];
    aw      = w_clamp[RpW-1:16];
    count1  = {1'b0, count} + 1'b1;
  end

  // crossfade decay: compare cf * 2^6 against the read/write difference
  always_comb begin
    rw_diff  = (StoreBits+1)'(interp_q) - (StoreBits+1)'(cur_q);
    diff_mag = StoreBits'(rw_diff < 0 ? -rw_diff : rw_diff);
    cf_decay = (GainW+3)'(cf_q >> 1) + (GainW+3)'(diff_mag >> 7);
    cf_next  = cf_q;
    if (StoreBits'({cf_q, 6'b0}) > diff_mag) begin
      cf_next = (cf_decay > (GainW+3)'(OneQ16)) ? GainW'(OneQ16) : GainW'(cf_decay);
    end
  end

  // RAM ports: clearing pass owns the write port after reset
  always_comb begin
    ram_we    = clearing_q || (state_q == S_WR);
    ram_waddr = clearing_q ? clr_q : AddrW'(wp_q);
    ram_wdata = clearing_q ? '0 : wdata_q;
    unique case (state_q)
      S_RD0:   ram_raddr = AddrW'(i0_q);
      S_RD1:   ram_raddr = AddrW'(i1_q);
      default: ram_raddr = AddrW'(curi_q);
    endcase
  end

  dlps_ram #(
    .Depth (BufDepth),
    .Width (StoreBits)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= WpW'(1);
      rp_q        <= RpW'(OneQ16);
      armed_q     <= 1'b0;
      cf_q        <= '0;
      last_q      <= '0;
      clearing_q  <= 1'b1;
      clr_q       <= '0;
      x_q         <= '0;
      prod_q      <= '0;
      prod_b_q    <= '0;
      neg_q       <= 1'b0;
      wdata_q     <= '0;
      i0_q        <= '0;
      i1_q        <= '0;
      curi_q      <= '0;
      frac_q      <= '0;
      cur_q       <= '0;
      interp_q    <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (clearing_q) begin
        clr_q <= clr_q + 1'b1;
        if (clr_q == AddrW'(BufDepth - 1)) begin
          clearing_q <= 1'b0;
        end
      end

      // S_OUT handles its own output transfer
      if (out_valid_q && out_ready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            x_q     <= in_sample_i;
            prod_q  <= prod;
            state_q <= S_SUM;
          end
        end
        S_SUM: begin
          neg_q   <= fb_sum < 0;
          wdata_q <= sat_store(SatW'(fb_sum));
          state_q <= need_div ? S_DIV : S_WR;
        end
        S_DIV: begin
          if (div_done) begin
            wdata_q <= sat_store(SatW'(div_signed));
            state_q <= S_WR;
          end
        end
        S_WR: begin
          // write slot goes out through the RAM port this cycle
          if (rp_inc > wp16 && armed_q) begin
            cf_q <= GainW'(OneQ16);
          end
          armed_q <= (rp_inc > w_clamp) ? 1'b1 : (armed_q && !(rp_inc > wp16));
          wp_q    <= wp_next;
          rp_q    <= rp_next;
          i0_q    <= (count > aw) ? {1'b0, count - aw - 1'b1} : {1'b0, count};
          i1_q    <= (count1 > {1'b0, aw}) ? {1'b0, count - aw} : count1;
          curi_q  <= wp_next;
          frac_q  <= rp_next[15:0];
          state_q <= S_RD0;
        end
        S_RD0: state_q <= S_RD1;
        S_RD1: begin
          prod_q  <= prod;
          state_q <= S_RD2;
        end
        S_RD2: begin
          prod_b_q <= prod;
          state_q  <= S_RD3;
        end
        S_RD3: begin
          cur_q    <= signed'(ram_rdata);
          interp_q <= StoreBits'(psum >>> 16);
          state_q  <= S_CF;
        end
        S_CF: begin
          cf_q    <= cf_next;
          state_q <= S_MIX0;
        end
        S_MIX0: begin
          prod_q  <= prod;
          state_q <= S_MIX1;
        end
        S_MIX1: begin
          prod_b_q <= prod;
          state_q  <= S_MIX2;
        end
        S_MIX2: begin
          last_q  <= sat_store(SatW'(psum >>> 16));
          state_q <= S_TRIM;
        end
        S_TRIM: begin
          prod_q  <= prod;
          state_q <= S_WET0;
        end
        S_WET0: begin
          prod_q  <= prod;
          state_q <= S_WET1;
        end
        S_WET1: begin
          prod_b_q <= prod;
          state_q  <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid_q || out_ready_i) begin
            out_q       <= sat_sample(SatW'(psum >>> 16));
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `DLPS_ASSERT(a_cf_range, cf_q <= GainW'(OneQ16), "crossfade level above unity")
  `DLPS_ASSERT_NEXT(a_busy_after_xfer, in_xfer, !in_ready_o, "ready after input transfer")
  `DLPS_ASSERT(a_div_done_state, !div_done || (state_q == S_DIV), "divider done outside wait")
  `DLPS_ASSERT_NEXT(a_out_stall, (state_q == S_OUT) && out_valid_q && !out_ready_i, state_q == S_OUT, "result overwrote pending output")

endmodule

// ----- tb/tb_delay_line_pitch_shifter.sv -----
`timescale 1ns / 100ps

module tb_delay_line_pitch_shifter;
  import dlps_pkg::*;

  localparam int unsigned SettleCycles = 80;
  localparam longint unsigned CycleLimit = 2_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [SampleBits-1:0] in_sample_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [SampleBits-1:0] out_sample_o;

  // shifter state mirror
  longint sample_mem [BufDepth];
  int unsigned wr_ptr, rd_ptr, xfade;
  bit armed;
  longint prev_out;
  int unsigned speed, width, fb_gain, trim, wet;

  logic signed [SampleBits-1:0] shifted_q[$];
  int unsigned n_errors = 0;
  longint unsigned cycle_cnt = 0;

  // receiver controls
  bit rx_hold = 1'b0;
  bit calm = 1'b0;

  delay_line_pitch_shifter i_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("tb_delay_line_pitch_shifter failed");
      $finish;
    end
  end

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip(longint v, int bits);
    longint lim;
    lim = longint'(1) << (bits - 1);
    if (v > lim - 1) return lim - 1;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  task automatic clear_model();
    foreach (sample_mem[i]) sample_mem[i] = 0;
    wr_ptr = 1; rd_ptr = OneQ16; armed = 0; xfade = 0; prev_out = 0;
    speed = 65536; width = 12026982; fb_gain = 0; trim = 65536; wet = 65536;
  endtask

  // one sample through the mirror; returns the expected shifted sample
  function automatic logic signed [SampleBits-1:0] shift_sample(
      logic signed [SampleBits-1:0] xin);
    longint one, x, fbv, afb, sum, interp, cur, diff, mixed, y, s0, s1;
    longint unsigned m, d, q, wp16, dq, ncf;
    int unsigned w, cnt, aw, i0, i1, frac, cf;
    one = longint'(1) << FracBits;
    x = xin;
    fbv = prev_out;
    afb = mag(fbv);
    sum = x + fshr(fbv * longint'(fb_gain), 16);
    if (afb > one) begin
      m = mag(sum);
      d = afb;
      q = ((m / d) << FracBits) + (((m % d) << FracBits) / d);
      sum = sum < 0 ? -longint'(q) : longint'(q);
    end
    sample_mem[wr_ptr % BufDepth] = clip(sum, StoreBits);
    w = width;
    if (w < WidthMin) w = WidthMin;
    if (w > WidthMax) w = WidthMax;
    wr_ptr = (wr_ptr + 1) & 32'h3FFF;
    rd_ptr = (rd_ptr + speed) & 32'h3FFF_FFFF;
    wp16 = longint'(wr_ptr) << 16;
    if (longint'(rd_ptr) > wp16 && armed) begin
      xfade = OneQ16;
      armed = 0;
    end
    if (wp16 > w) wr_ptr = int'((wp16 - w) >> 16) & 32'h3FFF;
    if (rd_ptr > w) begin
      rd_ptr -= w;
      armed = 1;
    end
    cnt = rd_ptr >> 16;
    aw = w >> 16;
    i0 = cnt > aw ? cnt - aw - 1 : cnt;
    i1 = (cnt + 1) > aw ? cnt - aw : cnt + 1;
    frac = rd_ptr & 32'hFFFF;
    s0 = sample_mem[i0 % BufDepth];
    s1 = sample_mem[i1 % BufDepth];
    interp = fshr(s0 * longint'(OneQ16 - frac) + s1 * longint'(frac), 16);
    cur = sample_mem[wr_ptr % BufDepth];
    diff = mag(interp - cur);
    cf = xfade;
    if (longint'(cf) * one > diff * 2 * longint'(OneQ16)) begin
      dq = (longint'(diff) << 16) >> FracBits;
      ncf = longint'(cf >> 1) + dq;
      if (ncf > OneQ16) ncf = OneQ16;
      cf = int'(ncf);
    end
    xfade = cf;
    mixed = clip(fshr(cur * longint'(cf) + interp * longint'(OneQ16 - cf), 16), StoreBits);
    prev_out = mixed;
    y = fshr(mixed * longint'(trim), 16);
    y = fshr(y * longint'(wet) + x * (longint'(OneQ16) - longint'(wet)), 16);
    return SampleBits'(clip(y, SampleBits));
  endfunction

  // receiver: random stalls, optional long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !rx_hold && (calm || $urandom_range(99) >= 14);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    logic signed [SampleBits-1:0] exp_s;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (shifted_q.size() == 0) begin
        $error("unexpected out_sample transfer: %0d", out_sample_o);
        n_errors++;
      end else begin
        exp_s = shifted_q.pop_front();
        if (out_sample_o !== exp_s) begin
          $error("out_sample expected %0d actual %0d", exp_s, out_sample_o);
          n_errors++;
        end
      end
    end
  end

  // the block is busy right after a transfer, so the gap cycle costs nothing
  task automatic send_sample(logic signed [SampleBits-1:0] s);
    if (!calm) begin
      while ($urandom_range(99) < 14) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_sample_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    shifted_q.push_back(shift_sample(s));
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (shifted_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CfgDataW'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgReadSpeed:  speed = val & 32'h7FFFF;
      CfgLoopWidth:  width = val & 32'h3FFF_FFFF;
      CfgFeedback:   fb_gain = val & 32'h1FFFF;
      CfgOutputTrim: trim = val & 32'h1FFFF;
      CfgWetMix:     wet = val & 32'h1FFFF;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic logic signed [SampleBits-1:0] rand_sample();
    case ($urandom_range(5))
      0: return SampleBits'($urandom_range(1) ? 24'h7FFFFF : 24'h800000);
      1: return SampleBits'($urandom_range(15)) - 8;
      default: return SampleBits'($urandom);
    endcase
  endfunction

  // extremes of the sample range and the default settings
  task automatic test_directed_extremes();
    logic signed [SampleBits-1:0] pat[] = '{24'h7FFFFF, 24'h800000, 24'h0, 24'h1,
        24'hFFFFFF, 24'h555555, 24'hAAAAAA, 24'h400000, 24'hC00000, 24'h7FFFFF};
    foreach (pat[i]) send_sample(pat[i]);
    drain();
  endtask

  // full feedback with hot input so |last output| exceeds one (division path)
  task automatic test_feedback_overload();
    write_reg(CfgLoopWidth, 4 << 16);
    write_reg(CfgFeedback, 65536);
    write_reg(CfgOutputTrim, 131071);
    write_reg(CfgWetMix, 131071);
    for (int i = 0; i < 10; i++) send_sample(i[0] ? 24'h7FFFFF : 24'h800000);
    drain();
  endtask

  // width clamps and speed above width
  task automatic test_width_edges();
    write_reg(CfgFeedback, 0);
    write_reg(CfgOutputTrim, 65536);
    write_reg(CfgWetMix, 65536);
    write_reg(CfgLoopWidth, 0);
    write_reg(CfgReadSpeed, 262144);
    for (int i = 0; i < 5; i++) send_sample(rand_sample());
    drain();
    write_reg(CfgLoopWidth, 30'h3FFF_FFFF);
    write_reg(CfgReadSpeed, 19'h7FFFF);
    for (int i = 0; i < 5; i++) send_sample(rand_sample());
    drain();
  endtask

  // long receiver hold-off: the block must back-pressure its input
  task automatic test_backpressure();
    write_reg(CfgReadSpeed, 98304);
    write_reg(CfgLoopWidth, 200 << 16);
    rx_hold = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk_i);
        rx_hold = 1'b0;
      end
      for (int i = 0; i < 20; i++) send_sample(rand_sample());
    join
    drain();
  endtask

  // random sweeps over settings, with a calm stretch in the middle
  task automatic test_random_sweep();
    int unsigned spd, wid;
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: spd = 16384;
        1: spd = 262144;
        default: spd = $urandom_range(16384, 262144);
      endcase
      wid = (ph % 3 == 0) ? $urandom_range(65536, 64 << 16) : $urandom_range(0, 30'h3FFF_FFFF);
      if (ph == 5) wid = WidthMax;
      write_reg(CfgReadSpeed, spd);
      write_reg(CfgLoopWidth, wid);
      write_reg(CfgFeedback, (ph % 4 == 2) ? 65536 : $urandom_range(0, 65536));
      write_reg(CfgOutputTrim, (ph == 3) ? 0 : $urandom_range(0, 131071));
      write_reg(CfgWetMix, (ph == 7) ? 0 : $urandom_range(0, 131071));
      calm = (ph == 6);
      for (int i = 0; i < 40; i++) send_sample(rand_sample());
      calm = 1'b0;
      drain();
    end
  endtask

  initial begin
    clear_model();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_extremes();
    test_feedback_overload();
    test_width_edges();
    test_backpressure();
    test_random_sweep();
    if (n_errors == 0) begin
      $display("tb_delay_line_pitch_shifter passed");
    end else begin
      $display("tb_delay_line_pitch_shifter failed");
    end
    $finish;
  end

endmodule
